// ===== src/mei_pkg.sv =====
// Shared constants for the Mandelbrot escape-time iteration unit.
package mei_pkg;

  localparam int CoordWidth    = 32;
  localparam int CoordFracBits = 28;
  localparam int ProdWidth     = 2 * CoordWidth;
  localparam int CountWidth    = 16;
  localparam int CfgWidth      = 16;

  localparam logic [CfgWidth-1:0] CfgReset = CfgWidth'(255);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;

endpackage

// ===== src/mei_if.sv =====
// Point and count channels of the Mandelbrot escape-time iteration unit.
interface mei_point_if;
  import mei_pkg::*;

  logic   valid;
  logic   ready;
  coord_t c_real;
  coord_t c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface mei_count_if #(
  parameter int COUNT_WIDTH = mei_pkg::CountWidth
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] iteration_count;

  modport source (output valid, output iteration_count, input ready);
  modport sink (input valid, input iteration_count, output ready);
endinterface

// ===== src/mei_mul.sv =====
// Shared signed multiplier with registered product.
module mei_mul (
  input  logic            clk,
  input  mei_pkg::coord_t a,
  input  mei_pkg::coord_t b,
  output mei_pkg::prod_t  prod
);
  import mei_pkg::*;

  always_ff @(posedge clk) begin
    prod <= prod_t'(a) * prod_t'(b);
  end
endmodule

// ===== src/mandelbrot_escape_iterations_unit.sv =====
// Mandelbrot escape-time iteration unit: top level with round sequencer.
// A round steps through S_LIM, S_XX, S_YY, S_XY and S_UPD, paced by the single shared
// 32x32 multiplier that forms zr*zr, zi*zi and zr*zi one after another.
// Throughput: one point at a time; a new point is taken once the last is done.
// Reset: synchronous; clears the sequencer and result valid, limit returns to 255.
module mandelbrot_escape_iterations_unit #(
  parameter int COUNT_WIDTH = mei_pkg::CountWidth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mei_pkg::CfgWidth-1:0]  cfg_wdata,
  mei_point_if.sink                     point,
  mei_count_if.source                   result
);
  import mei_pkg::*;

  localparam int LimWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;
  localparam logic [LimWidth-1:0] CountMax = LimWidth'({COUNT_WIDTH{1'b1}});
  localparam logic [ProdWidth-1:0] EscFour = ProdWidth'(4) << CoordFracBits;
  localparam logic [CoordFracBits-1:0] FracZero = '0;

  typedef enum logic [2:0] {
    S_IDLE, S_LIM, S_XX, S_YY, S_XY, S_UPD, S_DONE
  } state_t;

  state_t                  state;
  logic [CfgWidth-1:0]     max_iterations;
  coord_t                  cr, ci, zr, zi;
  prod_t                   xx, yy, xy, prod;
  logic                    esc;
  logic [COUNT_WIDTH-1:0]  count;
  logic                    res_valid;
  logic [COUNT_WIDTH-1:0]  res_count;

  coord_t                  mul_a, mul_b;
  logic [LimWidth-1:0]     limit;
  logic [ProdWidth-1:0]    sum_sq, sum_hi;
  logic                    esc_next;
  prod_t                   nr, ni;
  coord_t                  zr_next, zi_next;

  function automatic coord_t sat(input prod_t v);
    coord_t r;
    r = v[CoordWidth-1:0];
    if (v[ProdWidth-1] && !(&v[ProdWidth-1:CoordWidth-1])) begin
      r = {1'b1, {(CoordWidth-1){1'b0}}};
    end else if (!v[ProdWidth-1] && (|v[ProdWidth-1:CoordWidth-1])) begin
      r = {1'b0, {(CoordWidth-1){1'b1}}};
    end
    return r;
  endfunction

  mei_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    unique case (state)
      S_LIM: begin
        mul_a = zr;
        mul_b = zr;
      end
      S_XX: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zi;
      end
    endcase
  end

  always_comb begin
    limit    = (LimWidth'(max_iterations) > CountMax) ? CountMax : LimWidth'(max_iterations);
    sum_sq   = xx + yy;
    sum_hi   = sum_sq >> CoordFracBits;
    esc_next = (sum_hi > EscFour) ||
               ((sum_hi == EscFour) && (sum_sq[CoordFracBits-1:0] != FracZero));
    nr       = ((xx - yy) >>> CoordFracBits) + prod_t'(cr);
    ni       = (xy >>> (CoordFracBits - 1)) + prod_t'(ci);
    zr_next  = sat(nr);
    zi_next  = sat(ni);
  end

  assign point.ready            = (state == S_IDLE) && !rst;
  assign result.valid           = res_valid;
  assign result.iteration_count = res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      max_iterations <= CfgReset;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_iterations <= cfg_wdata;
      end
      if ((state == S_DONE) && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (point.valid) begin
            cr    <= point.c_real;
            ci    <= point.c_imag;
            zr    <= '0;
            zi    <= '0;
            count <= '0;
            state <= S_LIM;
          end
        end
        S_LIM: begin
          if (LimWidth'(count) >= limit) begin
            state <= S_DONE;
          end else begin
            state <= S_XX;
          end
        end
        S_XX: begin
          xx    <= prod;
          state <= S_YY;
        end
        S_YY: begin
          yy    <= prod;
          state <= S_XY;
        end
        S_XY: begin
          xy    <= prod;
          esc   <= esc_next;
          state <= S_UPD;
        end
        S_UPD: begin
          if (esc) begin
            state <= S_DONE;
          end else begin
            zr    <= zr_next;
            zi    <= zi_next;
            count <= count + COUNT_WIDTH'(1);
            state <= S_LIM;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_count <= count;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/mandelbrot_escape_iterations_unit_checker.sv =====
// Escape-count predictor and scoreboard for the Mandelbrot escape-time iteration unit.
`timescale 1ns / 100ps
module mandelbrot_escape_iterations_unit_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mei_pkg::CfgWidth-1:0] cfg_wdata,
  mei_point_if                         point,
  mei_count_if                         result,
  output int                           fail_count,
  output int                           outstanding,
  output int                           checked
);
  import mei_pkg::*;

  localparam coord_t CoordMax = {1'b0, {(CoordWidth - 1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordWidth - 1){1'b0}}};
  localparam logic [ProdWidth-1:0] EscapeBound = ProdWidth'(4) << (2 * CoordFracBits);

  typedef struct {
    coord_t                c_real;
    coord_t                c_imag;
    logic [CountWidth-1:0] rounds;
  } point_count_t;

  point_count_t          expected_counts[$];
  point_count_t          oldest;
  logic [CfgWidth-1:0]   round_limit;

  function automatic coord_t clamp_coord(prod_t v);
    if (v > prod_t'(CoordMax)) return CoordMax;
    if (v < prod_t'(CoordMin)) return CoordMin;
    return coord_t'(v);
  endfunction

  function automatic logic [CountWidth-1:0] escape_rounds(coord_t cr, coord_t ci,
                                                          logic [CfgWidth-1:0] cap);
    coord_t zr;
    coord_t zi;
    prod_t  rr;
    prod_t  ii;
    prod_t  ri;
    int     rounds;
    zr = '0;
    zi = '0;
    for (rounds = 0; rounds < int'(cap); rounds++) begin
      rr = prod_t'(zr) * prod_t'(zr);
      ii = prod_t'(zi) * prod_t'(zi);
      ri = prod_t'(zr) * prod_t'(zi);
      if ($unsigned(rr) + $unsigned(ii) > EscapeBound) break;
      zr = clamp_coord(((rr - ii) >>> CoordFracBits) + prod_t'(cr));
      zi = clamp_coord((ri >>> (CoordFracBits - 1)) + prod_t'(ci));
    end
    return CountWidth'(rounds);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      round_limit = CfgReset;
      expected_counts.delete();
    end else begin
      if (cfg_we) round_limit = cfg_wdata;
      if (point.valid && point.ready)
        expected_counts.push_back('{point.c_real, point.c_imag,
                                    escape_rounds(point.c_real, point.c_imag, round_limit)});
      if (result.valid && result.ready) begin
        if (expected_counts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("count %0d transferred with no point waiting", result.iteration_count);
        end else begin
          oldest = expected_counts.pop_front();
          checked++;
          if (result.iteration_count !== oldest.rounds) begin
            fail_count++;
            if (fail_count <= 10)
              $display("count mismatch for c = (%0d, %0d): expected %0d, got %0d",
                       oldest.c_real, oldest.c_imag, oldest.rounds, result.iteration_count);
          end
        end
      end
    end
    outstanding <= expected_counts.size();
  end

endmodule

// ===== tb/mandelbrot_escape_iterations_unit_tb.sv =====
// Stimulus, handshake pacing and verdict for the Mandelbrot escape-time iteration unit.
`timescale 1ns / 100ps
module mandelbrot_escape_iterations_unit_tb;
  import mei_pkg::*;

  localparam int     IdleLimit = 2_000_000;
  localparam coord_t One       = coord_t'(1 << CoordFracBits);
  localparam coord_t CoordMax  = {1'b0, {(CoordWidth - 1){1'b1}}};
  localparam coord_t CoordMin  = {1'b1, {(CoordWidth - 1){1'b0}}};

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgWidth-1:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int checked;
  int points_sent = 0;
  int limits_written = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  bit steady = 1'b0;

  mei_point_if point ();
  mei_count_if result ();

  always #10 clk = ~clk;

  mandelbrot_escape_iterations_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .point     (point),
    .result    (result)
  );

  mandelbrot_escape_iterations_unit_checker count_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .point       (point),
    .result      (result),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  task automatic send_point(input coord_t cr, input coord_t ci);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      point.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point.valid  <= 1'b1;
    point.c_real <= cr;
    point.c_imag <= ci;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
    points_sent++;
  endtask

  // drain the block before touching the limit
  task automatic set_limit(input logic [CfgWidth-1:0] limit);
    point.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    limits_written++;
  endtask

  function automatic coord_t pick_coord(int unsigned style);
    case (style)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      default: return coord_t'(int'($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst || (point.valid && point.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("no transfer for %0d cycles", idle_cycles);
    $display("mandelbrot_escape_iterations_unit regression: fail");
    $finish;
  end

  initial begin
    int stall;
    result.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        stall    = hold_off;
        hold_off = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      while (!result.valid) @(posedge clk);
    end
  end

  initial begin
    int                  blk;
    int                  k;
    int unsigned         style;
    logic [CfgWidth-1:0] limit;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    point.valid  <= 1'b0;
    point.c_real <= '0;
    point.c_imag <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_point('0, '0);
    send_point(-2 * One, '0);
    send_point(2 * One, '0);
    send_point('0, 2 * One);
    send_point(One / 4, '0);
    send_point('0, One);
    send_point(-One, '0);
    send_point(-3 * One / 4, One / 10);
    send_point(CoordMax, CoordMax);
    send_point(CoordMin, CoordMin);
    send_point(CoordMin, CoordMax);
    send_point(-1, -1);
    send_point(1, -1);

    set_limit('0);
    send_point('0, '0);
    send_point(CoordMax, '0);

    set_limit(CfgWidth'(1));
    send_point('0, '0);
    send_point(2 * One, '0);

    set_limit('1);
    send_point('0, '0);
    send_point(2 * One, '0);
    send_point(CoordMin, '0);

    set_limit(CfgWidth'(2));
    send_point(2 * One, '0);
    send_point('0, 2 * One);

    for (blk = 0; blk < 15; blk++) begin
      limit = ($urandom_range(0, 9) == 0) ? CfgWidth'($urandom_range(100, 300))
                                          : CfgWidth'($urandom_range(0, 48));
      set_limit(limit);
      steady = (blk == 5);
      if (blk == 3) hold_off = 300;
      for (k = 0; k < 75; k++) begin
        style = (blk == 3) ? 0 : $urandom_range(0, 7);
        style = (style < 2) ? 0 : (style < 6) ? 1 : 2;
        send_point(pick_coord(style), pick_coord(style));
      end
      steady = 1'b0;
    end

    point.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("ran %0d points across %0d limit settings (0 and 65535 included)",
             points_sent, limits_written + 1);
    $display("%0d counts checked, %0d failures, %0d counts missing",
             checked, fail_count, outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("mandelbrot_escape_iterations_unit regression: pass");
    else
      $display("mandelbrot_escape_iterations_unit regression: fail");
    $finish;
  end

endmodule
